### rtl/cp_tensor_predict_loss_macros.svh
// assertion macros for the cp tensor prediction and loss block
// no dependencies; included by the files that assert
`ifndef CP_TENSOR_PREDICT_LOSS_MACROS_SVH
`define CP_TENSOR_PREDICT_LOSS_MACROS_SVH
`ifndef SYNTH
`define CPTPL_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cptpl assertion failed");
`define CPTPL_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cptpl implication failed");
`else
`define CPTPL_ASSERT(name, clk, rst_n, prop)
`define CPTPL_ASSERT_IMP(name, clk, rst_n, ante, cons)
`endif
`endif

### rtl/cptpl_pkg.sv
// shared constants, types and codes of the cp tensor prediction and loss block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cptpl_pkg;

  localparam int RANK   = 16;
  localparam int ROWS   = 1024;
  localparam int NMODES = 3;

  localparam int FAC_W      = (RANK > 1) ? $clog2(RANK) : 1;
  localparam int ROW_W      = $clog2(ROWS);
  localparam int ADDR_W     = ROW_W + FAC_W;
  localparam int BANK_DEPTH = ROWS * (2 ** FAC_W);

  localparam int ELEM_W = 16;
  localparam int SUM_W  = ELEM_W + 1;
  localparam int P1_W   = 2 * SUM_W;
  localparam int P2_W   = 3 * SUM_W;
  localparam int TERM_W = P2_W + 3;
  localparam int ACC_W  = TERM_W + FAC_W + 1;
  localparam int RND_SH = 23;
  localparam logic [ACC_W-1:0] RND_ADD = ACC_W'(64'd1 << (RND_SH - 1));

  typedef logic signed [SUM_W-1:0] elem_t;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_SCORE = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_ROUND,
    S_SAT,
    S_ERR,
    S_MAG,
    S_SQ,
    S_ACC
  } state_t;

  typedef struct packed {
    logic                     en;
    logic                     set;
    logic [1:0]               mode;
    logic [ADDR_W-1:0]        addr;
    logic signed [ELEM_W-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic                        en;
    logic [NMODES-1:0][ROW_W-1:0] row;
    logic [FAC_W-1:0]            fac;
    logic [NMODES-1:0]           zero;
    logic                        avg;
  } rd_req_t;

endpackage

`default_nettype wire

### rtl/cptpl_ram.sv
// generic single-clock ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module cptpl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/cptpl_store.sv
// factor storage: one main and one aux bank per tensor mode, element forming
// depends on cptpl_pkg and cptpl_ram
`timescale 1ns / 1ps
`default_nettype none

module cptpl_store import cptpl_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire wr_req_t              wr,
  input  wire rd_req_t              rd,
  output logic                      vld,
  output elem_t [NMODES-1:0]        elem
);

  logic                           vld_r;
  logic [NMODES-1:0]              zero_r;
  logic                           avg_r;
  logic [NMODES-1:0][ELEM_W-1:0]  main_q;
  logic [NMODES-1:0][ELEM_W-1:0]  aux_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= rd.en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      zero_r <= rd.zero;
      avg_r  <= rd.avg;
    end
  end

  genvar m;
  generate
    for (m = 0; m < NMODES; m++) begin : g_bank
      logic [ADDR_W-1:0] raddr;
      logic              we_main;
      logic              we_aux;

      assign raddr   = {rd.row[m], rd.fac};
      assign we_main = wr.en && !wr.set && (wr.mode == 2'(m));
      assign we_aux  = wr.en && wr.set && (wr.mode == 2'(m));

      cptpl_ram #(.WIDTH(ELEM_W), .DEPTH(BANK_DEPTH)) u_main (
        .clk   (clk),
        .we    (we_main),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd.en),
        .raddr (raddr),
        .rdata (main_q[m])
      );

      cptpl_ram #(.WIDTH(ELEM_W), .DEPTH(BANK_DEPTH)) u_aux (
        .clk   (clk),
        .we    (we_aux),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd.en),
        .raddr (raddr),
        .rdata (aux_q[m])
      );

      // averaged mode keeps main + aux; the halving is folded into the scale
      assign elem[m] = zero_r[m] ? '0 :
                       avg_r ? SUM_W'($signed(main_q[m])) + SUM_W'($signed(aux_q[m])) :
                               SUM_W'($signed(main_q[m]));
    end
  endgenerate

  assign vld = vld_r;

endmodule

`default_nettype wire

### rtl/cptpl_mac.sv
// three-way product pipeline and rank accumulator with rounding bias
// depends on cptpl_pkg
`timescale 1ns / 1ps
`default_nettype none

module cptpl_mac import cptpl_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic                     rnd,
  input  wire logic                     avg,
  input  wire logic                     in_vld,
  input  wire elem_t [NMODES-1:0]       elem,
  output logic signed [ACC_W-1:0]       acc,
  output logic                          busy
);

  logic signed [P1_W-1:0]   p1_r;
  elem_t                    c_r;
  logic signed [P2_W-1:0]   p2_r;
  logic                     p1_vld_r;
  logic                     p2_vld_r;
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= in_vld;
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_r  <= P1_W'($signed(elem[0])) * P1_W'($signed(elem[1]));
    c_r   <= elem[2];
    p2_r  <= P2_W'(p1_r) * P2_W'(c_r);
    acc_r <= acc_nxt;
  end

  // main-only terms are scaled by 8 to share the averaged scale
  assign term = avg ? TERM_W'(p2_r) : (TERM_W'(p2_r) <<< 3);

  always_comb begin
    acc_nxt = acc_r;
    if (start) begin
      acc_nxt = '0;
    end else if (rnd) begin
      acc_nxt = acc_r + $signed(RND_ADD);
    end else if (p2_vld_r) begin
      acc_nxt = acc_r + ACC_W'(term);
    end
  end

  assign acc  = acc_r;
  assign busy = p1_vld_r | p2_vld_r;

endmodule

`default_nettype wire

### rtl/cp_tensor_predict_loss.sv
// cp tensor prediction and loss: top level, depends on cptpl_pkg, cptpl_store, cptpl_mac
// score: one read per cycle from each factor bank, then the drain, round, saturate,
// error, magnitude, square and accumulate states; no new item is taken until the
// score is done, and a stalled result holds the next score at its last stage
// writes and clears are taken in idle; the result register lets the next item in
// reset clears control, error sums and count; factor memories are not initialized
`timescale 1ns / 1ps
`default_nettype none
`include "cp_tensor_predict_loss_macros.svh"

module cp_tensor_predict_loss import cptpl_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_average_aux,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_cmd,
  input  wire logic               in_matrix_set,
  input  wire logic [1:0]         in_mode,
  input  wire logic [9:0]         in_row,
  input  wire logic [3:0]         in_factor,
  input  wire logic signed [15:0] in_element,
  input  wire logic [9:0]         in_idx_i,
  input  wire logic [9:0]         in_idx_j,
  input  wire logic [9:0]         in_idx_k,
  input  wire logic signed [31:0] in_observed,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_predicted,
  output logic signed [31:0]      out_error,
  output logic [63:0]             out_sum_sq_error,
  output logic [47:0]             out_sum_abs_error,
  output logic [31:0]             out_scored_count
);

  state_t                      state_r, state_nxt;
  logic [FAC_W-1:0]            f_cnt_r, f_cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [63:0]                 sum_sq_r, sum_sq_nxt;
  logic [47:0]                 sum_abs_r, sum_abs_nxt;
  logic [31:0]                 score_cnt_r, score_cnt_nxt;
  logic                        avg_r;

  logic [NMODES-1:0][ROW_W-1:0] rows_r;
  logic [NMODES-1:0]           zero_r;
  logic signed [31:0]          obs_r;
  logic signed [31:0]          pred_r;
  logic signed [31:0]          err_r;
  logic [31:0]                 mag_r;
  logic [63:0]                 sq_r;
  logic signed [31:0]          out_pred_r;
  logic signed [31:0]          out_err_r;
  logic [63:0]                 out_sq_r;
  logic [47:0]                 out_abs_r;
  logic [31:0]                 out_cnt_r;

  logic                        in_xfer;
  logic                        score_acc;
  logic                        clr_acc;
  logic                        out_load;
  wr_req_t                     wr_req;
  rd_req_t                     rd_req;
  logic                        elem_vld;
  elem_t [NMODES-1:0]          elem;
  logic signed [ACC_W-1:0]     mac_acc;
  logic                        mac_busy;
  logic signed [ACC_W-1:0]     acc_sh;
  logic [ACC_W-32:0]           acc_hi;
  logic signed [31:0]          pred_sat;
  logic signed [32:0]          diff;
  logic signed [31:0]          err_sat;
  logic [64:0]                 sq_sum;
  logic [48:0]                 abs_sum;
  logic [63:0]                 sq_upd;
  logic [47:0]                 abs_upd;
  logic [31:0]                 cnt_upd;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign score_acc = in_xfer && (in_cmd == CMD_SCORE);
  assign clr_acc   = in_xfer && (in_cmd == CMD_CLEAR);
  assign out_load  = (state_r == S_ACC) && (!out_valid_r || out_ready);

  // factor element writes go straight to the banks
  always_comb begin
    wr_req.en   = in_xfer && (in_cmd == CMD_WRITE) &&
                  (32'(in_mode) < 32'(NMODES)) &&
                  (32'(in_row) < 32'(ROWS)) &&
                  (32'(in_factor) < 32'(RANK));
    wr_req.set  = in_matrix_set;
    wr_req.mode = in_mode;
    wr_req.addr = {ROW_W'(in_row), FAC_W'(in_factor)};
    wr_req.data = in_element;
  end

  always_comb begin
    rd_req.en   = (state_r == S_RUN);
    rd_req.row  = rows_r;
    rd_req.fac  = f_cnt_r;
    rd_req.zero = zero_r;
    rd_req.avg  = avg_r;
  end

  cptpl_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr_req),
    .rd    (rd_req),
    .vld   (elem_vld),
    .elem  (elem)
  );

  cptpl_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (score_acc),
    .rnd    (state_r == S_ROUND),
    .avg    (avg_r),
    .in_vld (elem_vld),
    .elem   (elem),
    .acc    (mac_acc),
    .busy   (mac_busy)
  );

  // rounded accumulator to q16.16 with saturation
  assign acc_sh = mac_acc >>> RND_SH;
  assign acc_hi = acc_sh[ACC_W-1:31];
  always_comb begin
    if (acc_hi == '0 || acc_hi == '1) begin
      pred_sat = acc_sh[31:0];
    end else if (acc_sh[ACC_W-1]) begin
      pred_sat = 32'sh8000_0000;
    end else begin
      pred_sat = 32'sh7FFF_FFFF;
    end
  end

  assign diff = 33'(obs_r) - 33'(pred_r);
  always_comb begin
    if (diff[32] == diff[31]) begin
      err_sat = diff[31:0];
    end else if (diff[32]) begin
      err_sat = 32'sh8000_0000;
    end else begin
      err_sat = 32'sh7FFF_FFFF;
    end
  end

  assign sq_sum  = {1'b0, sum_sq_r} + {1'b0, sq_r};
  assign abs_sum = {1'b0, sum_abs_r} + 49'(mag_r);
  assign sq_upd  = sq_sum[64] ? '1 : sq_sum[63:0];
  assign abs_upd = abs_sum[48] ? '1 : abs_sum[47:0];
  assign cnt_upd = (score_cnt_r == '1) ? score_cnt_r : score_cnt_r + 32'd1;

  always_comb begin
    state_nxt     = state_r;
    f_cnt_nxt     = f_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    sum_sq_nxt    = sum_sq_r;
    sum_abs_nxt   = sum_abs_r;
    score_cnt_nxt = score_cnt_r;
    case (state_r)
      S_IDLE: begin
        if (score_acc) begin
          state_nxt = S_RUN;
          f_cnt_nxt = '0;
        end else if (clr_acc) begin
          sum_sq_nxt    = '0;
          sum_abs_nxt   = '0;
          score_cnt_nxt = '0;
        end
      end
      S_RUN: begin
        f_cnt_nxt = f_cnt_r + FAC_W'(1);
        if (f_cnt_r == FAC_W'(RANK - 1)) begin
          f_cnt_nxt = '0;
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!elem_vld && !mac_busy) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: state_nxt = S_SAT;
      S_SAT:   state_nxt = S_ERR;
      S_ERR:   state_nxt = S_MAG;
      S_MAG:   state_nxt = S_SQ;
      S_SQ:    state_nxt = S_ACC;
      S_ACC: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          sum_sq_nxt    = sq_upd;
          sum_abs_nxt   = abs_upd;
          score_cnt_nxt = cnt_upd;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      f_cnt_r     <= '0;
      out_valid_r <= 1'b0;
      sum_sq_r    <= '0;
      sum_abs_r   <= '0;
      score_cnt_r <= '0;
      avg_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      f_cnt_r     <= f_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      sum_sq_r    <= sum_sq_nxt;
      sum_abs_r   <= sum_abs_nxt;
      score_cnt_r <= score_cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        avg_r <= cfg_average_aux;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (score_acc) begin
      rows_r[0] <= ROW_W'(in_idx_i);
      rows_r[1] <= ROW_W'(in_idx_j);
      rows_r[2] <= ROW_W'(in_idx_k);
      zero_r[0] <= (32'(in_idx_i) >= 32'(ROWS));
      zero_r[1] <= (32'(in_idx_j) >= 32'(ROWS));
      zero_r[2] <= (32'(in_idx_k) >= 32'(ROWS));
      obs_r     <= in_observed;
    end
    if (state_r == S_SAT) begin
      pred_r <= pred_sat;
    end
    if (state_r == S_ERR) begin
      err_r <= err_sat;
    end
    if (state_r == S_MAG) begin
      mag_r <= err_r[31] ? (~err_r + 32'd1) : err_r;
    end
    if (state_r == S_SQ) begin
      sq_r <= 64'(mag_r) * 64'(mag_r);
    end
    if (out_load) begin
      out_pred_r <= pred_r;
      out_err_r  <= err_r;
      out_sq_r   <= sq_upd;
      out_abs_r  <= abs_upd;
      out_cnt_r  <= cnt_upd;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_predicted     = out_pred_r;
  assign out_error         = out_err_r;
  assign out_sum_sq_error  = out_sq_r;
  assign out_sum_abs_error = out_abs_r;
  assign out_scored_count  = out_cnt_r;

  `CPTPL_ASSERT_IMP(a_drain_empty, clk, rst_n, state_r == S_ROUND, !elem_vld && !mac_busy)
  `CPTPL_ASSERT_IMP(a_run_bound, clk, rst_n, state_r == S_RUN, 32'(f_cnt_r) < 32'(RANK))
  `CPTPL_ASSERT(a_cnt_hold, clk, rst_n, ($past(rst_n) && $past(state_r) != S_ACC && !$past(clr_acc)) |-> $stable(score_cnt_r))
  `CPTPL_ASSERT(a_out_from_acc, clk, rst_n, ($past(rst_n) && $rose(out_valid_r)) |-> $past(state_r) == S_ACC)

endmodule

`default_nettype wire

### tb/sv/tb_cp_tensor_predict_loss.sv
// testbench for cp_tensor_predict_loss: loads factor rows, scores nonzeros in both
// prediction modes and checks every result against a local fixed-point predictor
// depends on cptpl_pkg and the cp_tensor_predict_loss rtl
`timescale 1ns / 1ps

module tb_cp_tensor_predict_loss import cptpl_pkg::*; ();

  localparam int NSETS = 2;
  localparam int SET_MAIN = 0;
  localparam int SET_AUX = 1;
  localparam logic [1:0] MODE_INVALID = 2'(NMODES);
  localparam logic [15:0] ELEM_MAX = 16'h7FFF;
  localparam logic [15:0] ELEM_MIN = 16'h8000;
  localparam logic signed [31:0] Q16_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q16_MIN = 32'sh8000_0000;
  localparam logic [47:0] ABS_MAX = '1;
  localparam int SETTLE_CYCLES = 40;

  typedef enum {FILL_RANDOM, FILL_MAX, FILL_MIN} fill_t;

  typedef struct packed {
    cmd_t        cmd;
    logic        set;
    logic [1:0]  mode;
    logic [9:0]  row;
    logic [3:0]  factor;
    logic [15:0] element;
    logic [9:0]  idx_i;
    logic [9:0]  idx_j;
    logic [9:0]  idx_k;
    logic [31:0] observed;
  } tensor_req_t;

  typedef struct packed {
    logic [31:0] predicted;
    logic [31:0] error;
    logic [63:0] sum_sq;
    logic [47:0] sum_abs;
    logic [31:0] count;
  } score_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_average_aux = 1'b0;
  logic in_valid = 1'b0;
  logic [1:0] in_cmd = '0;
  logic in_matrix_set = 1'b0;
  logic [1:0] in_mode = '0;
  logic [9:0] in_row = '0;
  logic [3:0] in_factor = '0;
  logic signed [15:0] in_element = '0;
  logic [9:0] in_idx_i = '0;
  logic [9:0] in_idx_j = '0;
  logic [9:0] in_idx_k = '0;
  logic signed [31:0] in_observed = '0;
  logic out_ready = 1'b0;
  logic cfg_ready;
  logic in_ready;
  logic out_valid;
  logic signed [31:0] out_predicted;
  logic signed [31:0] out_error;
  logic [63:0] out_sum_sq_error;
  logic [47:0] out_sum_abs_error;
  logic [31:0] out_scored_count;

  // predictor state
  logic signed [15:0] factor_mem [NSETS][NMODES][ROWS][RANK];
  logic avg_mode = 1'b0;
  logic [63:0] sq_total = '0;
  logic [47:0] abs_total = '0;
  logic [31:0] scored_total = '0;
  score_result_t pending_scores [$];
  score_result_t want;

  // rows written in full in both sets, the only ones a score may touch
  bit row_ready [NMODES][ROWS];
  logic [9:0] ready_list [NMODES][ROWS];
  int unsigned ready_cnt [NMODES];

  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned stall_left = 0;
  bit steady = 1'b0;

  cp_tensor_predict_loss u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_average_aux  (cfg_average_aux),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_matrix_set    (in_matrix_set),
    .in_mode          (in_mode),
    .in_row           (in_row),
    .in_factor        (in_factor),
    .in_element       (in_element),
    .in_idx_i         (in_idx_i),
    .in_idx_j         (in_idx_j),
    .in_idx_k         (in_idx_k),
    .in_observed      (in_observed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_predicted    (out_predicted),
    .out_error        (out_error),
    .out_sum_sq_error (out_sum_sq_error),
    .out_sum_abs_error(out_sum_abs_error),
    .out_scored_count (out_scored_count)
  );

  always #5 clk = ~clk;

  function automatic logic signed [31:0] clamp_q16(input longint v);
    if (v > Q16_MAX) return Q16_MAX;
    if (v < Q16_MIN) return Q16_MIN;
    return 32'(v);
  endfunction

  task automatic predict_loss(input tensor_req_t rq);
    logic [9:0] idx [NMODES];
    longint acc;
    longint term;
    longint e;
    longint q;
    logic [63:0] mag;
    logic [63:0] sq_next;
    logic [63:0] abs_next;
    score_result_t res;
    case (rq.cmd)
      CMD_WRITE: begin
        if (int'(rq.mode) < NMODES) begin
          factor_mem[rq.set][rq.mode][rq.row][rq.factor] = rq.element;
        end
      end
      CMD_CLEAR: begin
        sq_total = '0;
        abs_total = '0;
        scored_total = '0;
      end
      CMD_SCORE: begin
        idx[0] = rq.idx_i;
        idx[1] = rq.idx_j;
        idx[2] = rq.idx_k;
        acc = 0;
        for (int f = 0; f < RANK; f++) begin
          term = 1;
          for (int m = 0; m < NMODES; m++) begin
            e = factor_mem[SET_MAIN][m][idx[m]][f];
            if (avg_mode) e += factor_mem[SET_AUX][m][idx[m]][f];
            term *= e;
          end
          // main-only terms brought to the averaged scale
          if (!avg_mode) term *= 8;
          acc += term;
        end
        q = (acc + (64'sd1 <<< (RND_SH - 1))) >>> RND_SH;
        res.predicted = clamp_q16(q);
        res.error = clamp_q16(longint'($signed(rq.observed)) -
                              longint'($signed(res.predicted)));
        mag = ($signed(res.error) < 0) ? -longint'($signed(res.error))
                                       : longint'($signed(res.error));
        sq_next = sq_total + mag * mag;
        sq_total = (sq_next < sq_total) ? '1 : sq_next;
        abs_next = abs_total + mag;
        abs_total = (abs_next > ABS_MAX) ? ABS_MAX : abs_next[47:0];
        if (scored_total != '1) scored_total++;
        res.sum_sq = sq_total;
        res.sum_abs = abs_total;
        res.count = scored_total;
        pending_scores.push_back(res);
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // result side: random stalls unless in a steady stretch
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(99) < 35) begin
      out_ready <= 1'b0;
      stall_left <= ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_scores.size() == 0) begin
        $error("result transfer with no score pending");
        mismatches++;
      end else begin
        want = pending_scores.pop_front();
        check_field("predicted", $signed(want.predicted), out_predicted);
        check_field("error", $signed(want.error), out_error);
        check_field("sum_sq_error", want.sum_sq, out_sum_sq_error);
        check_field("sum_abs_error", want.sum_abs, out_sum_abs_error);
        check_field("scored_count", want.count, out_scored_count);
      end
    end
  end

  function automatic logic [15:0] rand_element();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($urandom_range(16383)) - 16'd8192;
  endfunction

  function automatic logic [31:0] rand_observed();
    case ($urandom_range(9))
      0: return $urandom_range(1) ? Q16_MAX : Q16_MIN;
      1, 2: return $urandom;
      default: return 32'($urandom_range(2097152)) - 32'd1048576;
    endcase
  endfunction

  function automatic tensor_req_t random_req();
    tensor_req_t rq;
    rq.cmd = cmd_t'($urandom_range(3));
    rq.set = 1'($urandom);
    rq.mode = 2'($urandom);
    rq.row = 10'($urandom);
    rq.factor = 4'($urandom);
    rq.element = 16'($urandom);
    rq.idx_i = 10'($urandom);
    rq.idx_j = 10'($urandom);
    rq.idx_k = 10'($urandom);
    rq.observed = $urandom;
    return rq;
  endfunction

  function automatic tensor_req_t score_req(input logic [9:0] i, input logic [9:0] j,
                                            input logic [9:0] k, input logic [31:0] obs);
    tensor_req_t rq;
    rq = random_req();
    rq.cmd = CMD_SCORE;
    rq.idx_i = i;
    rq.idx_j = j;
    rq.idx_k = k;
    rq.observed = obs;
    return rq;
  endfunction

  function automatic logic [9:0] pick_ready(input int m);
    return ready_list[m][$urandom_range(ready_cnt[m] - 1)];
  endfunction

  task automatic send_req(input tensor_req_t rq);
    in_valid <= 1'b1;
    in_cmd <= rq.cmd;
    in_matrix_set <= rq.set;
    in_mode <= rq.mode;
    in_row <= rq.row;
    in_factor <= rq.factor;
    in_element <= rq.element;
    in_idx_i <= rq.idx_i;
    in_idx_j <= rq.idx_j;
    in_idx_k <= rq.idx_k;
    in_observed <= rq.observed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_loss(rq);
    if (rq.cmd != CMD_NOP && !(rq.cmd == CMD_WRITE && rq.mode == MODE_INVALID)) begin
      items_sent++;
    end
    if (!steady && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(4, 1))
        @(posedge clk);
    end
  endtask

  task automatic send_cmd(input cmd_t c);
    tensor_req_t rq;
    rq = random_req();
    rq.cmd = c;
    send_req(rq);
  endtask

  // wait for every score transfer, then let trailing writes and clears settle
  task automatic drain_results();
    int unsigned guard;
    in_valid <= 1'b0;
    guard = 0;
    while (pending_scores.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_scores.size() != 0) begin
      $error("%0d results never arrived", pending_scores.size());
      mismatches++;
      pending_scores.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_average_aux(input logic v);
    cfg_valid <= 1'b1;
    cfg_average_aux <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    avg_mode = v;
  endtask

  task automatic load_row(input logic [1:0] m, input logic [9:0] r, input fill_t fill);
    tensor_req_t rq;
    for (int s = 0; s < NSETS; s++) begin
      for (int f = 0; f < RANK; f++) begin
        rq = random_req();
        rq.cmd = CMD_WRITE;
        rq.set = 1'(s);
        rq.mode = m;
        rq.row = r;
        rq.factor = 4'(f);
        case (fill)
          FILL_MAX: rq.element = ELEM_MAX;
          FILL_MIN: rq.element = ELEM_MIN;
          default: rq.element = rand_element();
        endcase
        send_req(rq);
      end
    end
    if (!row_ready[m][r]) begin
      row_ready[m][r] = 1'b1;
      ready_list[m][ready_cnt[m]] = r;
      ready_cnt[m]++;
    end
  endtask

  task automatic run_random_mix(input int unsigned n);
    int unsigned stop_at;
    int unsigned pick;
    tensor_req_t rq;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick == 80) begin
        load_row(2'($urandom_range(NMODES - 1)), 10'($urandom), FILL_RANDOM);
      end else begin
        rq = random_req();
        if (pick < 55) begin
          rq = score_req(pick_ready(0), pick_ready(1), pick_ready(2), rand_observed());
        end else if (pick < 80) begin
          rq.cmd = CMD_WRITE;
          rq.mode = 2'($urandom_range(NMODES - 1));
          rq.row = pick_ready(rq.mode);
          rq.element = rand_element();
        end else if (pick < 88) begin
          // arbitrary row, may stay partly written
          rq.cmd = CMD_WRITE;
          rq.mode = 2'($urandom_range(NMODES - 1));
        end else if (pick < 92) begin
          rq.cmd = CMD_WRITE;
          rq.mode = MODE_INVALID;
        end else if (pick < 95) begin
          rq.cmd = CMD_CLEAR;
        end else begin
          rq.cmd = CMD_NOP;
        end
        send_req(rq);
      end
    end
  endtask

  task automatic test_load_rows();
    for (int m = 0; m < NMODES; m++) begin
      load_row(2'(m), 10'd0, FILL_MAX);
      load_row(2'(m), 10'(ROWS - 1), FILL_MIN);
      load_row(2'(m), 10'($urandom), FILL_RANDOM);
      load_row(2'(m), 10'($urandom), FILL_RANDOM);
    end
  endtask

  task automatic test_main_only_extremes();
    tensor_req_t rq;
    // error saturates both ways, then the squared sum sticks at its top
    send_req(score_req(10'd0, 10'd0, 10'd0, Q16_MIN));
    send_req(score_req(10'(ROWS - 1), 10'(ROWS - 1), 10'(ROWS - 1), Q16_MAX));
    send_req(score_req(10'd0, 10'(ROWS - 1), 10'd0, 32'd0));
    send_req(score_req(10'(ROWS - 1), 10'd0, 10'(ROWS - 1), 32'hFFFF_FFFF));
    send_req(score_req(10'd0, 10'd0, 10'd0, Q16_MIN));
    send_req(score_req(10'(ROWS - 1), 10'(ROWS - 1), 10'(ROWS - 1), Q16_MAX));
    send_req(score_req(10'd0, 10'd0, 10'(ROWS - 1), Q16_MIN));
    send_cmd(CMD_NOP);
    rq = random_req();
    rq.cmd = CMD_WRITE;
    rq.mode = MODE_INVALID;
    rq.row = 10'd0;
    rq.element = 16'd0;
    send_req(rq);
    send_req(score_req(10'd0, 10'd0, 10'd0, 32'd0));
    send_cmd(CMD_CLEAR);
    send_req(score_req(10'(ROWS - 1), 10'(ROWS - 1), 10'(ROWS - 1), 32'd0));
  endtask

  task automatic test_averaged_extremes();
    send_req(score_req(10'd0, 10'd0, 10'd0, Q16_MIN));
    send_req(score_req(10'(ROWS - 1), 10'(ROWS - 1), 10'(ROWS - 1), Q16_MAX));
    send_req(score_req(10'd0, 10'(ROWS - 1), 10'(ROWS - 1), 32'd0));
    send_req(score_req(pick_ready(0), pick_ready(1), pick_ready(2), rand_observed()));
    send_cmd(CMD_CLEAR);
    send_req(score_req(10'(ROWS - 1), 10'd0, 10'd0, rand_observed()));
  endtask

  task automatic test_random_main_only();
    run_random_mix(400);
  endtask

  task automatic test_random_averaged();
    run_random_mix(360);
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    run_random_mix(220);
    drain_results();
    steady = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_average_aux(1'b0);
    test_load_rows();
    test_main_only_extremes();
    drain_results();
    write_average_aux(1'b1);
    test_averaged_extremes();
    drain_results();
    write_average_aux(1'b0);
    test_random_main_only();
    drain_results();
    write_average_aux(1'b1);
    test_random_averaged();
    drain_results();
    test_back_to_back();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
